// ----- rtl/wcs_pkg.sv -----
// Package with the widths, limits and register map of the coefficient shrinkage core.
`timescale 1ns / 1ps
`default_nettype none

package wcs_pkg;

	localparam int CoefW  = 16;
	localparam int ThrW   = 16;
	localparam int MagW   = 17;
	localparam int SqW    = 32;
	localparam int CountW = 21;
	localparam int SumW   = 51;
	localparam int OutW   = CoefW + CountW + SumW;
	localparam int AddrW  = 3;
	localparam int DataW  = 32;

	localparam int DefaultMaxCoeffs = 1048576;

	localparam logic [CountW-1:0] CountFieldMax = '1;
	localparam logic [SumW-1:0]   SumLimit      = {1'b1, {(SumW - 1){1'b0}}};

	typedef enum logic {
		RegThreshold = 1'b0,
		RegSoftMode  = 1'b1
	} reg_idx_t;

endpackage

`default_nettype wire

// ----- rtl/wavelet_coefficient_shrinkage_core.sv -----
// Top level of the wavelet coefficient shrinkage core with running GCV terms.
//
// The slave stream carries one signed coefficient per beat in s_tdata, with
// s_tlast marking the final coefficient of a channel. The master stream returns
// one beat per input beat: the thresholded value, the running count of zeroed
// coefficients and the running sum of squares, with m_tlast copying the flag.
// A beat passes from the input register through the stage 2 register to the
// output register before it shows on m_tvalid. One beat is taken every cycle
// while the receiver does not stall; the squaring multiplier and the 51-bit
// accumulate each sit in a stage of their own, and the accumulate is the only loop.
// The user must write the threshold and mode through the APB port only while the stream
// is idle; the block does not enforce it. Reset clears both registers, the accumulators
// and all stage valids. When the receiver stalls, the output register holds its beat and
// the earlier stages keep filling, so up to three beats are held before s_tready falls.
// The count and the sum clear after the beat that carries the last flag.
`timescale 1ns / 1ps
`default_nettype none

module wavelet_coefficient_shrinkage_core #(
	parameter int MAX_COEFFS = wcs_pkg::DefaultMaxCoeffs
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	// APB configuration port
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [wcs_pkg::AddrW-1:0]  paddr,
	input  wire logic [wcs_pkg::DataW-1:0]  pwdata,
	output logic      [wcs_pkg::DataW-1:0]  prdata,
	output logic                            pready,
	// Input stream
	input  wire logic                       s_tvalid,
	output logic                            s_tready,
	input  wire logic [wcs_pkg::CoefW-1:0]  s_tdata,  // coefficient[15:0]
	input  wire logic                       s_tlast,
	// Output stream
	output logic                            m_tvalid,
	input  wire logic                       m_tready,
	output logic      [wcs_pkg::OutW-1:0]   m_tdata,  // shrunk_value[15:0], zeroed_count[36:16],
	                                                  // square_sum[87:37]
	output logic                            m_tlast
);

	localparam int CoefW  = wcs_pkg::CoefW;
	localparam int ThrW   = wcs_pkg::ThrW;
	localparam int MagW   = wcs_pkg::MagW;
	localparam int SqW    = wcs_pkg::SqW;
	localparam int CountW = wcs_pkg::CountW;
	localparam int SumW   = wcs_pkg::SumW;
	localparam int DataW  = wcs_pkg::DataW;
	localparam int FieldMaxInt = (1 << CountW) - 1;
	localparam int LimitInt = (MAX_COEFFS < FieldMaxInt) ? MAX_COEFFS : FieldMaxInt;
	localparam logic [CountW-1:0] CountLimit = CountW'(LimitInt);

	logic [ThrW-1:0] threshold_q;
	logic            soft_mode_q;
	logic            cfg_write;
	wcs_pkg::reg_idx_t cfg_idx;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;
	assign cfg_idx   = wcs_pkg::reg_idx_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= '0;
			soft_mode_q <= 1'b0;
		end else if (cfg_write) begin
			unique case (cfg_idx)
				wcs_pkg::RegThreshold: threshold_q <= pwdata[ThrW-1:0];
				wcs_pkg::RegSoftMode:  soft_mode_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			wcs_pkg::RegThreshold: prdata = DataW'(threshold_q);
			wcs_pkg::RegSoftMode:  prdata = DataW'(soft_mode_q);
			default:               prdata = '0;
		endcase
	end

	// Stage valids and handshakes
	logic valid_s1, valid_s2, valid_s3;
	logic ready_s2, ready_s3;
	logic adv_s2, adv_s3;

	assign ready_s3 = !valid_s3 || m_tready;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign s_tready = !valid_s1 || ready_s2;
	assign adv_s2   = valid_s1 && ready_s2;
	assign adv_s3   = valid_s2 && ready_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
			if (ready_s3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	// Stage 1: input register
	logic signed [CoefW-1:0] coef_s1;
	logic                    last_s1;

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			coef_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	// Threshold compare, shrink and square
	logic signed [MagW-1:0] coef_ext;
	logic signed [MagW-1:0] thr_ext;
	logic        [MagW-1:0] mag;
	logic                   below;
	logic        [MagW-1:0] sq_op;
	logic        [SqW-1:0]  sq_full;
	logic       [CoefW-1:0] soft_val;
	logic        [CoefW-1:0] shrunk;

	always_comb begin
		coef_ext = MagW'(coef_s1);
		thr_ext  = signed'({1'b0, threshold_q});
		mag      = coef_s1[CoefW-1] ? unsigned'(-coef_ext) : unsigned'(coef_ext);
		below    = mag < {1'b0, threshold_q};
		sq_op    = below ? mag : {1'b0, threshold_q};
		sq_full  = SqW'(sq_op) * SqW'(sq_op);
		soft_val = (coef_ext > 0) ? CoefW'(coef_ext - thr_ext) : CoefW'(coef_ext + thr_ext);
		if (below) begin
			shrunk = '0;
		end else if (soft_mode_q) begin
			shrunk = soft_val;
		end else begin
			shrunk = coef_s1;
		end
	end

	// Stage 2: shrunk value and square term
	logic [CoefW-1:0] shrunk_s2;
	logic             last_s2;
	logic             below_s2;
	logic [SqW-1:0]   sq_s2;

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			shrunk_s2 <= shrunk;
			last_s2   <= last_s1;
			below_s2  <= below;
			sq_s2     <= sq_full;
		end
	end

	// Running accumulators
	logic [CountW-1:0] zero_q;
	logic [SumW-1:0]   sum_q;
	logic [CountW-1:0] count_next;
	logic [SumW-1:0]   sum_full;
	logic [SumW-1:0]   sum_next;

	always_comb begin
		count_next = (below_s2 && (zero_q < CountLimit)) ? zero_q + 1'b1 : zero_q;
		sum_full   = sum_q + SumW'(sq_s2);
		sum_next   = (sum_full > wcs_pkg::SumLimit) ? wcs_pkg::SumLimit : sum_full;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_q <= '0;
			sum_q  <= '0;
		end else if (adv_s3) begin
			zero_q <= last_s2 ? '0 : count_next;
			sum_q  <= last_s2 ? '0 : sum_next;
		end
	end

	// Stage 3: output register
	logic [CoefW-1:0]  shrunk_s3;
	logic              last_s3;
	logic [CountW-1:0] count_s3;
	logic [SumW-1:0]   sum_s3;

	always_ff @(posedge clk) begin
		if (adv_s3) begin
			shrunk_s3 <= shrunk_s2;
			last_s3   <= last_s2;
			count_s3  <= count_next;
			sum_s3    <= sum_next;
		end
	end

	assign m_tvalid = valid_s3;
	assign m_tdata  = {sum_s3, count_s3, shrunk_s3};
	assign m_tlast  = last_s3;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		zero_q <= CountLimit)
		else $error("zeroed count above its limit");

	a_sum_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sum_q <= wcs_pkg::SumLimit)
		else $error("square sum above its limit");

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s3 && last_s2) |=> (zero_q == '0) && (sum_q == '0))
		else $error("accumulators not cleared after the last beat");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && !m_tready) |=> $stable(zero_q) && $stable(sum_q))
		else $error("accumulators moved while the output was stalled");

	a_accept_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(!valid_s1 || !valid_s2 || !valid_s3) |-> s_tready)
		else $error("input stalled while a stage was free");

endmodule

`default_nettype wire
